### rtl/cipc_pkg.sv
package cipc_pkg;

  localparam int CHARGE_FRAC_BITS_DEF = 24;
  localparam int ANGLE_LIMIT          = 135;
  localparam int ANGLE_SPAN           = 2 * ANGLE_LIMIT + 1;

  // item operations
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // controller types
  localparam logic [1:0] MODE_JOYSTICK = 2'd0;
  localparam logic [1:0] MODE_PADDLE   = 2'd1;
  localparam logic [1:0] MODE_KEYPAD   = 2'd2;

  // register selects
  localparam logic [3:0] RS_POT0    = 4'd0;
  localparam logic [3:0] RS_POT1    = 4'd1;
  localparam logic [3:0] RS_POT2    = 4'd2;
  localparam logic [3:0] RS_POT3    = 4'd3;
  localparam logic [3:0] RS_FIRE0   = 4'd4;
  localparam logic [3:0] RS_FIRE1   = 4'd5;
  localparam logic [3:0] RS_PORTA   = 4'd6;
  localparam logic [3:0] RS_PORTA_D = 4'd7;
  localparam logic [3:0] RS_PORTB   = 4'd8;
  localparam logic [3:0] RS_PORTB_D = 4'd9;

  // configuration register indexes
  localparam logic [1:0] CFG_MODE       = 2'd0;
  localparam logic [1:0] CFG_COLOR      = 2'd1;
  localparam logic [1:0] CFG_LEFT_DIFF  = 2'd2;
  localparam logic [1:0] CFG_RIGHT_DIFF = 2'd3;

endpackage

### rtl/console_input_port_controller_core.sv
// Channel | Ports                                               | Direction
// in      | in_valid/in_ready, in_operation .. in_console_buttons | item in
// out     | out_valid/out_ready, out_read_data                  | read result
// cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data            | register write
//
// An item is taken into an input register, then decoded and applied to the
// port state as the input stage advances; a read's byte lands in the output
// register and is offered on out_valid from there. One item per cycle
// is sustained: the input stage moves on whenever it holds no read or the output
// register is free or being taken. Only a read waiting behind an unread result
// stalls input.
// Synchronous active-low reset clears the port state and empties both stages.
module console_input_port_controller_core
  import cipc_pkg::*;
#(
  parameter int CHARGE_FRAC_BITS = CHARGE_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [3:0]  in_reg_select,
  input  logic [7:0]  in_write_data,
  input  logic [1:0]  in_vblank_ctrl,
  input  logic [7:0]  in_stick_dirs,
  input  logic [5:0]  in_stick_buttons,
  input  logic [3:0]  in_paddle_buttons,
  input  logic [7:0]  in_paddle_turn,
  input  logic [11:0] in_left_pad_keys,
  input  logic [11:0] in_right_pad_keys,
  input  logic [1:0]  in_console_buttons,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_data
);

  localparam int CW = CHARGE_FRAC_BITS + 1;
  localparam logic [CW-1:0] FULL_C = {1'b1, {CHARGE_FRAC_BITS{1'b0}}};
  localparam logic [63:0] FULL64 = 64'd1 << CHARGE_FRAC_BITS;
  localparam int LO_N = 256;
  localparam int HI_N = ANGLE_SPAN - LO_N;

  // increment tables, split at index 256
  logic [CW-1:0] inc_lo [LO_N];
  logic [CW-1:0] inc_hi [HI_N];

  for (genvar a = 0; a < LO_N; a++) begin : g_inc_lo
    localparam logic [63:0] D = 64'(8664 * a + 27);
    localparam logic [63:0] V = (FULL64 * 64'd27 + D / 64'd2) / D;
    assign inc_lo[a] = V[CW-1:0];
  end

  for (genvar a = 0; a < HI_N; a++) begin : g_inc_hi
    localparam logic [63:0] D = 64'(8664 * (a + LO_N) + 27);
    localparam logic [63:0] V = (FULL64 * 64'd27 + D / 64'd2) / D;
    assign inc_hi[a] = V[CW-1:0];
  end

  // configuration
  logic [1:0] mode_r;
  logic       color_r, left_diff_r, right_diff_r;

  // input stage
  logic        s1_valid_r;
  logic [1:0]  op_r;
  logic [3:0]  sel_r;
  logic [7:0]  wdata_r;
  logic [1:0]  vblank_r;
  logic [7:0]  dirs_r;
  logic [5:0]  sbtn_r;
  logic [3:0]  pbtn_r;
  logic [7:0]  turn_r;
  logic [11:0] lkeys_r, rkeys_r;
  logic [1:0]  cbtn_r;

  // port state
  logic [7:0]          pa_data_r, pa_data_nxt;
  logic [7:0]          pa_dir_r, pa_dir_nxt;
  logic [7:0]          pb_dir_r, pb_dir_nxt;
  logic [3:0]          pot_r, pot_nxt;
  logic [1:0]          fire_r, fire_nxt;
  logic signed [8:0]   angle_r [4];
  logic signed [8:0]   angle_nxt [4];
  logic [CW-1:0]       charge_r [4];
  logic [CW-1:0]       charge_nxt [4];

  // output stage
  logic       out_valid_r;
  logic [7:0] out_data_r;

  logic       advance;
  logic       is_read;
  logic [7:0] rdata;

  assign is_read   = (op_r == OP_READ);
  assign advance   = s1_valid_r && (!is_read || !out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

  function automatic logic col_active(input logic [3:0] rows, input logic [11:0] keys,
                                      input int col);
    logic hit;
    hit = 1'b0;
    for (int r = 0; r < 4; r++) begin
      hit = hit | (rows[r] & keys[r * 3 + col]);
    end
    return hit;
  endfunction

  // register read mux
  always_comb begin
    rdata = 8'h00;
    unique case (sel_r) inside
      RS_POT0, RS_POT1, RS_POT2, RS_POT3: rdata = {pot_r[sel_r[1:0]], 7'b0};
      RS_FIRE0, RS_FIRE1:                 rdata = {fire_r[sel_r[0]], 7'b0};
      RS_PORTA:   rdata = pa_data_r & ~pa_dir_r;
      RS_PORTA_D: rdata = pa_dir_r;
      RS_PORTB:   rdata = {right_diff_r, left_diff_r, 2'b11, color_r, 1'b1,
                           ~cbtn_r[1], ~cbtn_r[0]} & ~pb_dir_r;
      RS_PORTB_D: rdata = pb_dir_r;
      default:    rdata = 8'h00;
    endcase
  end

  // state update for one item
  always_comb begin
    logic              dump, latch;
    logic [7:0]        rowsel;
    logic [3:0]        rows0, rows1;
    logic [1:0]        fire_val;
    logic signed [9:0] a_ext;
    logic signed [8:0] a_new;
    logic [8:0]        idx;
    logic [CW-1:0]     inc;
    logic [CW:0]       c_sum;

    pa_data_nxt = pa_data_r;
    pa_dir_nxt  = pa_dir_r;
    pb_dir_nxt  = pb_dir_r;
    pot_nxt     = pot_r;
    fire_nxt    = fire_r;
    for (int i = 0; i < 4; i++) begin
      angle_nxt[i]  = angle_r[i];
      charge_nxt[i] = charge_r[i];
    end

    dump   = vblank_r[0];
    latch  = vblank_r[1];
    rowsel = pa_dir_r & ~pa_data_r;
    rows0  = rowsel[7:4];
    rows1  = rowsel[3:0];
    fire_val = 2'b11;

    if (op_r == OP_WRITE) begin
      case (sel_r)
        RS_PORTA:   pa_data_nxt = (pa_dir_r & wdata_r) | (~pa_dir_r & pa_data_r);
        RS_PORTA_D: pa_dir_nxt  = wdata_r;
        RS_PORTB_D: pb_dir_nxt  = wdata_r;
        default:    ;
      endcase
    end else if (op_r == OP_TICK) begin
      for (int i = 0; i < 4; i++) begin
        a_ext = {angle_r[i][8], angle_r[i]} - {9'b0, turn_r[2 * i]}
                + {9'b0, turn_r[2 * i + 1]};
        if (a_ext < -10'sd135)     a_new = -9'sd135;
        else if (a_ext > 10'sd135) a_new = 9'sd135;
        else                       a_new = a_ext[8:0];
        angle_nxt[i] = a_new;
        idx = 9'(a_new + 9'sd135);
        inc = idx[8] ? inc_hi[idx[3:0]] : inc_lo[idx[7:0]];
        c_sum = dump ? '0 : ({1'b0, charge_r[i]} + {1'b0, inc});
        if (mode_r == MODE_PADDLE) begin
          // pot reads charged once it reaches full, then hold at full
          if (c_sum >= {1'b0, FULL_C}) begin
            pot_nxt[i]    = 1'b1;
            charge_nxt[i] = FULL_C;
          end else begin
            pot_nxt[i]    = 1'b0;
            charge_nxt[i] = c_sum[CW-1:0];
          end
        end
      end

      case (mode_r)
        MODE_JOYSTICK: begin
          pa_data_nxt = ~dirs_r;
          pot_nxt  = dump ? 4'b0000 : {sbtn_r[5], sbtn_r[4], sbtn_r[2], sbtn_r[1]};
          fire_val = {~sbtn_r[3], ~sbtn_r[0]};
          fire_nxt = latch ? (fire_r & fire_val) : fire_val;
        end
        MODE_PADDLE: begin
          pa_data_nxt = {~pbtn_r[0], ~pbtn_r[1], 2'b00, ~pbtn_r[2], ~pbtn_r[3], 2'b00};
        end
        MODE_KEYPAD: begin
          if (dump) begin
            pot_nxt = 4'b0000;
          end else begin
            pot_nxt = {~col_active(rows1, rkeys_r, 1), ~col_active(rows1, rkeys_r, 0),
                       ~col_active(rows0, lkeys_r, 1), ~col_active(rows0, lkeys_r, 0)};
          end
          fire_val = {~col_active(rows1, rkeys_r, 2), ~col_active(rows0, lkeys_r, 2)};
          fire_nxt = latch ? (fire_r & fire_val) : fire_val;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_JOYSTICK;
      color_r      <= 1'b1;
      left_diff_r  <= 1'b0;
      right_diff_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MODE:       mode_r       <= cfg_data;
        CFG_COLOR:      color_r      <= cfg_data[0];
        CFG_LEFT_DIFF:  left_diff_r  <= cfg_data[0];
        CFG_RIGHT_DIFF: right_diff_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      op_r     <= in_operation;
      sel_r    <= in_reg_select;
      wdata_r  <= in_write_data;
      vblank_r <= in_vblank_ctrl;
      dirs_r   <= in_stick_dirs;
      sbtn_r   <= in_stick_buttons;
      pbtn_r   <= in_paddle_buttons;
      turn_r   <= in_paddle_turn;
      lkeys_r  <= in_left_pad_keys;
      rkeys_r  <= in_right_pad_keys;
      cbtn_r   <= in_console_buttons;
    end
  end

  // port state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pa_data_r <= 8'h00;
      pa_dir_r  <= 8'h00;
      pb_dir_r  <= 8'h00;
      pot_r     <= 4'hF;
      fire_r    <= 2'b11;
      for (int i = 0; i < 4; i++) begin
        angle_r[i]  <= '0;
        charge_r[i] <= '0;
      end
    end else if (advance) begin
      pa_data_r <= pa_data_nxt;
      pa_dir_r  <= pa_dir_nxt;
      pb_dir_r  <= pb_dir_nxt;
      pot_r     <= pot_nxt;
      fire_r    <= fire_nxt;
      for (int i = 0; i < 4; i++) begin
        angle_r[i]  <= angle_nxt[i];
        charge_r[i] <= charge_nxt[i];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && is_read) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (advance && is_read) begin
      out_data_r <= rdata;
    end
  end

`ifndef SYNTHESIS
  logic angles_ok, charges_ok;
  always_comb begin
    angles_ok  = 1'b1;
    charges_ok = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (angle_r[i] < -9'sd135 || angle_r[i] > 9'sd135) angles_ok = 1'b0;
      if (charge_r[i] > FULL_C) charges_ok = 1'b0;
    end
  end

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n) angles_ok)
    else $error("paddle angle out of range");

  a_charge_sat: assert property (@(posedge clk) disable iff (!rst_n) charges_ok)
    else $error("paddle charge above full");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && is_read && out_valid_r && !out_ready))
    else $error("input stalled without a pending read");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && is_read) |=> out_valid_r)
    else $error("read item produced no result");
`endif

endmodule
